[hdl/wfa_pkg.sv]
// ----------------------------------------------------------------------------
// Worst-fit allocator package
// Field widths, command codes and reset constants shared by the allocator.
// ----------------------------------------------------------------------------
package wfa_pkg;

    localparam int CMD_W    = 1;
    localparam int SLOT_W   = 4;
    localparam int AMOUNT_W = 16;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

endpackage

[hdl/wfa_if.sv]
// ----------------------------------------------------------------------------
// Worst-fit allocator channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface wfa_req_if
    import wfa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, output cmd, output slot, output amount, input ready);
    modport sink   (input valid, input cmd, input slot, input amount, output ready);
endinterface

interface wfa_rsp_if
    import wfa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                granted;
    logic [SLOT_W-1:0]   chosen_block;
    logic [AMOUNT_W-1:0] left_in_block;

    modport source (output valid, output granted, output chosen_block,
                    output left_in_block, input ready);
    modport sink   (input valid, input granted, input chosen_block,
                    input left_in_block, output ready);
endinterface

[hdl/wfa_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/worst_fit_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// Worst-fit block allocator core
// Holds the free size of each block slot in a RAM, and for each allocate
// word scans the active slots for the largest one that fits, then charges it.
//
//   Channel | Dir | Handshake      | Payload
//   --------+-----+----------------+-----------------------------------------
//   req     | in  | valid/ready    | cmd, slot, amount
//   rsp     | out | valid/ready    | granted, chosen_block, left_in_block
//   cfg     | in  | cfg_we         | cfg_wdata = block_count
//
// A load word is written to the RAM as it is accepted, and the core stays ready.
// An allocate word runs from its accept to the next accept through the accept
// cycle, one RAM read per slot, a wait for the registered read data, and a
// write back that also loads the response register.
// Reset marks every slot as unwritten, so it reads as zero; no clearing pass.
// A pending response stalls only the final cycle of the next allocate.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator_core
    import wfa_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    wfa_req_if.sink            req,
    wfa_rsp_if.source          rsp
);

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    block_count_reg;
    logic [CW-1:0]         issue_cnt_reg, issue_cnt_next;
    logic                  pend_reg, pend_next;
    logic                  found_reg, found_next;
    logic [NUM_BLOCKS-1:0] written_reg;
    logic                  vbit_q_reg;
    logic [AW-1:0]         cmp_idx_reg;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    logic [SIZE_WIDTH-1:0] best_val_reg, best_val_next;
    logic [SIZE_WIDTH-1:0] req_reg;
    logic                  out_valid_reg;
    logic                  out_granted_reg;
    logic [SLOT_W-1:0]     out_block_reg;
    logic [AMOUNT_W-1:0]   out_left_reg;

    logic [CW-1:0]         active;
    logic                  accept;
    logic                  load_ok;
    logic                  issue;
    logic                  finish_fire;
    logic                  hit;
    logic [SIZE_WIDTH-1:0] cur_val;
    logic [SIZE_WIDTH-1:0] new_val;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [SIZE_WIDTH-1:0] ram_wdata;
    logic [SIZE_WIDTH-1:0] ram_rdata;

    always_comb
    begin
        if (32'(block_count_reg) > NUM_BLOCKS)
        begin
            active = CW'(NUM_BLOCKS);
        end
        else
        begin
            active = CW'(block_count_reg);
        end
    end

    assign req.ready   = (state_reg == ST_IDLE);
    assign accept      = req.valid && req.ready;
    assign load_ok     = accept && (req.cmd == CMD_LOAD) && (32'(req.slot) < NUM_BLOCKS);
    assign issue       = (state_reg == ST_SCAN) && (issue_cnt_reg < active);
    assign finish_fire = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    assign cur_val = vbit_q_reg ? ram_rdata : '0;
    assign hit     = pend_reg && (cur_val >= req_reg) && (!found_reg || (best_val_reg < cur_val));
    assign new_val = best_val_reg - req_reg;

    always_comb
    begin
        if (state_reg == ST_FINISH)
        begin
            ram_we    = finish_fire && found_reg;
            ram_waddr = best_idx_reg;
            ram_wdata = new_val;
        end
        else
        begin
            ram_we    = load_ok;
            ram_waddr = AW'(req.slot);
            ram_wdata = SIZE_WIDTH'(req.amount);
        end
    end

    wfa_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (NUM_BLOCKS)
    ) u_free_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        if (hit)
        begin
            found_next    = 1'b1;
            best_idx_next = cmp_idx_reg;
            best_val_next = cur_val;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.cmd == CMD_ALLOC))
                begin
                    state_next     = ST_SCAN;
                    issue_cnt_next = '0;
                    found_next     = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    pend_next      = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            block_count_reg <= COUNT_RESET;
            issue_cnt_reg   <= '0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            written_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            if (cfg_we)
            begin
                block_count_reg <= cfg_wdata;
            end
            if (ram_we)
            begin
                written_reg[ram_waddr] <= 1'b1;
            end
            if (finish_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        if (accept)
        begin
            req_reg <= SIZE_WIDTH'(req.amount);
        end
        if (issue)
        begin
            cmp_idx_reg <= issue_cnt_reg[AW-1:0];
            vbit_q_reg  <= written_reg[issue_cnt_reg[AW-1:0]];
        end
        if (finish_fire)
        begin
            out_granted_reg <= found_reg;
            out_block_reg   <= found_reg ? SLOT_W'(best_idx_reg) : '0;
            out_left_reg    <= found_reg ? AMOUNT_W'(new_val) : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted       = out_granted_reg;
    assign rsp.chosen_block  = out_block_reg;
    assign rsp.left_in_block = out_left_reg;

    a_refused_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.granted) |-> (rsp.chosen_block == '0 && rsp.left_in_block == '0))
        else $error("Refused response carries a nonzero slot or size.");

    a_scan_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= active))
        else $error("Scan counter ran past the active slots.");

    a_best_fits : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && found_reg) |-> (best_val_reg >= req_reg))
        else $error("Chosen slot is smaller than the request.");

    a_no_read_at_finish : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> !pend_reg)
        else $error("Write-back reached with a RAM read still in flight.");

    a_finish_to_resp : assert property (@(posedge clk) disable iff (!rst_n)
        finish_fire |=> (rsp.valid && state_reg == ST_IDLE))
        else $error("Finished allocate did not present a response.");

endmodule
